FILE: src/lapedge_pkg.sv
// Shared types, constants and register codes for the Laplacian edge threshold block.
package lapedge_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 8;
    localparam int IMG_W_W       = 11;
    localparam int IMG_H_W       = 16;
    localparam int THR_W         = 10;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;

    localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
    localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd480;
    localparam logic [THR_W-1:0]   THR_RST   = 10'd30;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef struct packed {
        logic             frame_end;
        logic [PIX_W-1:0] edge_pixel;
    } t_result;

endpackage

FILE: src/lapedge_line_mem.sv
// Two-row line memory: one write port, two registered read ports with write forwarding.
module lapedge_line_mem #(
    parameter int DEPTH = lapedge_pkg::MAX_WIDTH_DEF,
    parameter int DW    = 2 * lapedge_pkg::PIX_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [DW-1:0] o_rdata0,
    output logic [DW-1:0] o_rdata1
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd0;
    logic [DW-1:0] r_rd1;

    // Write and read in the same cycle; a read of the entry being written
    // returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[i_waddr] <= i_wdata;
            r_rd0 <= (i_waddr == i_raddr0) ? i_wdata : r_mem[i_raddr0];
            r_rd1 <= (i_waddr == i_raddr1) ? i_wdata : r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

FILE: src/lapedge_skid.sv
// Output register with one skid entry between the datapath and the result channel.
module lapedge_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lapedge_pkg::t_result i_data,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lapedge_pkg::t_result o_data,
    output logic                 o_skid_busy
);

    logic                 r_out_valid;
    logic                 r_skid_valid;
    lapedge_pkg::t_result r_out;
    lapedge_pkg::t_result r_skid;
    logic                 pop;

    assign pop = r_out_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out       <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_space     = ~r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_skid_busy = r_skid_valid;

endmodule

FILE: src/laplacian_edge_threshold.sv
// Top level of the streaming 4-neighbour Laplacian edge detector with threshold.
//
// Usage: grey pixels enter in raster order on the s_ channel (s_tdata = pixel,
// s_tuser = opcode, 0 for a pixel item, 1 for a drain item). Binary edge pixels
// leave on the m_ channel (m_tdata = 0 or 255, m_tlast = last result of a frame).
// Results lag their pixels by one row: the item at row r >= 1 gives the result
// for row r-1 at the same column; row 0 gives none. After the last pixel of a
// frame, each drain item releases one bottom-row zero; m_tlast marks the last.
// Throughput: one item per cycle while s_tready is high. The line memory is read
// ahead for the next column (two read ports), so a result is computed in the accept
// cycle and registered in the output register, or in the skid entry while that is full.
// Stall: an output register and one skid entry hold results; s_tready drops only
// while the skid entry is occupied, and clears as soon as the receiver takes one.
// Reset: positions clear, registers return to width 640, height 480, threshold 30.
// The line memory is not cleared; the first two rows of a frame seed it.
// Registers (APB, byte addresses): 0x0 image_width, 0x4 image_height,
// 0x8 edge_threshold. Write them only while the block is idle.
module laplacian_edge_threshold #(
    parameter int MAX_WIDTH = lapedge_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] pixel_value
    input  logic                             s_tuser,   // [0] opcode
    // Result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] edge_pixel
    output logic                             m_tlast,   // frame_end
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lapedge_pkg::APB_AW-1:0]   paddr,
    input  logic [lapedge_pkg::APB_DW-1:0]   pwdata,
    output logic [lapedge_pkg::APB_DW-1:0]   prdata,
    output logic                             pready
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WW0 > lapedge_pkg::IMG_W_W) ? WW0 : lapedge_pkg::IMG_W_W;
    localparam int PW  = lapedge_pkg::PIX_W;
    localparam int HW  = lapedge_pkg::IMG_H_W;

    // ---------------- configuration registers ----------------
    logic [lapedge_pkg::IMG_W_W-1:0] r_img_w;
    logic [HW-1:0]                   r_img_h;
    logic [lapedge_pkg::THR_W-1:0]   r_thr;
    logic                            cfg_wr;
    logic [1:0]                      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= lapedge_pkg::IMG_W_RST;
            r_img_h <= lapedge_pkg::IMG_H_RST;
            r_thr   <= lapedge_pkg::THR_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                lapedge_pkg::REG_IMAGE_WIDTH:    r_img_w <= pwdata[lapedge_pkg::IMG_W_W-1:0];
                lapedge_pkg::REG_IMAGE_HEIGHT:   r_img_h <= pwdata[HW-1:0];
                lapedge_pkg::REG_EDGE_THRESHOLD: r_thr   <= pwdata[lapedge_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lapedge_pkg::REG_IMAGE_WIDTH:
                prdata = lapedge_pkg::APB_DW'(r_img_w);
            lapedge_pkg::REG_IMAGE_HEIGHT:
                prdata = lapedge_pkg::APB_DW'(r_img_h);
            lapedge_pkg::REG_EDGE_THRESHOLD:
                prdata = lapedge_pkg::APB_DW'(r_thr);
            default:
                prdata = '0;
        endcase
    end

    // Effective frame size: zero acts as one, width clamps to the memory depth
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb begin
        if (r_img_w == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_img_w) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_img_w);
        end
    end

    assign h_eff = (r_img_h == '0) ? HW'(1) : r_img_h;

    // ---------------- position state ----------------
    logic [AW-1:0] r_col;
    logic [HW-1:0] r_row;
    logic [AW-1:0] r_drain;
    logic          r_draining;
    logic [PW-1:0] r_left;

    logic [AW-1:0] n_col;
    logic [HW-1:0] n_row;
    logic [AW-1:0] n_drain;
    logic          n_draining;

    logic          step;
    logic          pix_step;
    logic          drain_step;
    logic          skid_space;
    logic          skid_busy;

    assign s_tready   = skid_space;
    assign step       = s_tvalid & s_tready;
    assign pix_step   = step & (s_tuser == lapedge_pkg::OP_PIXEL) & ~r_draining;
    assign drain_step = step & (s_tuser == lapedge_pkg::OP_DRAIN) & r_draining;

    // Read data of the line memory: entry of this column and of the next one
    logic [2*PW-1:0] rd_here;
    logic [2*PW-1:0] rd_next;
    logic [PW-1:0]   up_pix;
    logic [PW-1:0]   centre;
    logic [PW-1:0]   right_pix;

    assign up_pix    = rd_here[2*PW-1:PW];
    assign centre    = rd_here[PW-1:0];
    assign right_pix = rd_next[PW-1:0];

    // Position arithmetic
    logic [WW:0] c_ext;
    logic        last_col;
    logic        last_row;
    logic        last_drain;
    logic        emit;
    logic        interior;

    assign c_ext      = (WW + 1)'(r_col);
    assign last_col   = (c_ext + 1'b1) >= (WW + 1)'(w_eff);
    assign last_row   = ((HW + 1)'(r_row) + 1'b1) >= (HW + 1)'(h_eff);
    assign last_drain = ((WW + 1)'(r_drain) + 1'b1) >= (WW + 1)'(w_eff);
    assign emit       = (r_row != '0);
    assign interior   = emit && (r_row >= HW'(2)) && (r_col != '0)
                      && ((c_ext + 2'd2) <= (WW + 1)'(w_eff))
                      && ((c_ext + 1'b1) < (WW + 1)'(MAX_WIDTH));

    // Laplacian and threshold
    logic [PW+1:0] sum4;
    logic [PW+2:0] lap;
    logic [PW+2:0] lap_neg;
    logic [PW+1:0] lap_abs;
    logic          is_edge;

    assign sum4    = (PW + 2)'(up_pix) + (PW + 2)'(s_tdata)
                   + (PW + 2)'(r_left) + (PW + 2)'(right_pix);
    assign lap     = (PW + 3)'(sum4) - (PW + 3)'({centre, 2'b00});
    assign lap_neg = -lap;
    assign lap_abs = lap[PW+2] ? lap_neg[PW+1:0] : lap[PW+1:0];
    assign is_edge = interior && (lap_abs > r_thr);

    // Next position and the read addresses for the column after this one
    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_drain    = r_drain;
        n_draining = r_draining;
        if (pix_step) begin
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row      = '0;
                    n_draining = 1'b1;
                    n_drain    = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end else if (drain_step) begin
            if (last_drain) begin
                n_draining = 1'b0;
                n_drain    = '0;
            end else begin
                n_drain = r_drain + 1'b1;
            end
        end
    end

    assign rd_addr0 = n_col;
    assign rd_addr1 = (((WW + 1)'(n_col) + 1'b1) >= (WW + 1)'(MAX_WIDTH)) ? '0 : n_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_drain    <= '0;
            r_draining <= 1'b0;
            r_left     <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_drain    <= n_drain;
            r_draining <= n_draining;
            if (pix_step) begin
                r_left <= centre;
            end
        end
    end

    // Entry holds {older row, newer row}; shift the column down one row
    lapedge_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * PW),
        .AW    (AW)
    ) u_line_mem (
        .i_clk    (i_clk),
        .i_en     (pix_step),
        .i_waddr  (r_col),
        .i_wdata  ({centre, s_tdata}),
        .i_raddr0 (rd_addr0),
        .i_raddr1 (rd_addr1),
        .o_rdata0 (rd_here),
        .o_rdata1 (rd_next)
    );

    // ---------------- result path ----------------
    logic                 push;
    lapedge_pkg::t_result push_data;
    lapedge_pkg::t_result out_data;

    assign push = (pix_step & emit) | drain_step;

    always_comb begin
        push_data.edge_pixel = is_edge ? lapedge_pkg::EDGE_ON : lapedge_pkg::EDGE_OFF;
        push_data.frame_end  = 1'b0;
        if (drain_step) begin
            push_data.edge_pixel = lapedge_pkg::EDGE_OFF;
            push_data.frame_end  = last_drain;
        end
    end

    lapedge_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (push_data),
        .o_space     (skid_space),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_data      (out_data),
        .o_skid_busy (skid_busy)
    );

    assign m_tdata = out_data.edge_pixel;
    assign m_tlast = out_data.frame_end;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_busy |-> m_tvalid)
        else $error("skid entry occupied while output register empty");

    a_frame_end_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_data.frame_end) |-> drain_step)
        else $error("frame end raised on a pixel result");

    a_drain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_step |-> (push_data.edge_pixel == lapedge_pkg::EDGE_OFF))
        else $error("drain result not zero");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drain_step && last_drain) |=> (!r_draining && r_drain == '0))
        else $error("draining not closed after last bottom-row result");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_step && last_col && last_row) |=> (r_draining && r_row == '0 && r_col == '0))
        else $error("frame end did not start draining");

endmodule

FILE: test/laplacian_edge_threshold_tb.sv
// Self-checking testbench for the streaming Laplacian edge threshold block.
module laplacian_edge_threshold_tb;
    import lapedge_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;

    // Clock, reset and block ports; every input starts at a known value
    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;     // [7:0] pixel_value
    logic               s_tuser  = 1'b0;   // [0] opcode
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;           // [7:0] edge_pixel
    logic               m_tlast;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [APB_AW-1:0]  paddr    = '0;
    logic [APB_DW-1:0]  pwdata   = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Idle knobs: percent of cycles the sender idles or the receiver stalls
    int tx_pct  = 0;
    int rx_pct  = 0;
    logic hold_rx = 1'b0;   // long receiver hold-off, owned by its own process
    int fails   = 0;
    int frame_no = 0;       // random frame count, walks the size and threshold corners

    // Register copies as the block should hold them
    logic [IMG_W_W-1:0] cfg_width  = IMG_W_RST;
    logic [IMG_H_W-1:0] cfg_height = IMG_H_RST;
    logic [THR_W-1:0]   cfg_thr    = THR_RST;

    // Predictor state: two line stores, left neighbour and raster position
    logic [7:0]  rows_older [MAX_W] = '{default: '0};
    logic [7:0]  rows_newer [MAX_W] = '{default: '0};
    logic [7:0]  left_pix  = '0;
    logic [9:0]  col_at    = '0;
    logic [15:0] row_at    = '0;
    logic [10:0] drain_at  = '0;
    bit          draining  = 1'b0;

    // Edge pixels still owed by the block, oldest first
    t_result expected_edges [$];

    // Directed stimulus: op, pixel, typed expectation?, result due, edge, last.
    // Rows with typed = 0 take their expectation from the predictor.
    typedef struct packed {
        t_opcode    op;
        logic [7:0] pix;
        logic       typed;
        logic       due;
        logic [7:0] edge_pixel;
        logic       last;
    } t_step;

    t_step bench_rows [26] = '{
        // drain before any frame is complete: dropped
        '{OP_DRAIN, 8'd0,   1'b1, 1'b0, EDGE_OFF, 1'b0},
        // frame A, 3x3: row 0 gives nothing
        '{OP_PIXEL, 8'd0,   1'b1, 1'b0, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd255, 1'b1, 1'b0, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b0, EDGE_OFF, 1'b0},
        // row 1 releases the top border row
        '{OP_PIXEL, 8'd255, 1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd255, 1'b1, 1'b1, EDGE_OFF, 1'b0},
        // row 2: left and right border zero, centre is a +1020 Laplacian
        '{OP_PIXEL, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd255, 1'b0, 1'b0, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        // pixel arriving while the bottom row is pending: dropped
        '{OP_PIXEL, 8'd77,  1'b1, 1'b0, EDGE_OFF, 1'b0},
        '{OP_DRAIN, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_DRAIN, 8'd255, 1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_DRAIN, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b1},
        // frame B: bright centre on black, a -1020 Laplacian
        '{OP_PIXEL, 8'd0,   1'b1, 1'b0, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b0, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b0, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd255, 1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
        '{OP_PIXEL, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_DRAIN, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_DRAIN, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b0},
        '{OP_DRAIN, 8'd0,   1'b1, 1'b1, EDGE_OFF, 1'b1}
    };

    laplacian_edge_threshold #(
        .MAX_WIDTH (MAX_W)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // Width 0 acts as 1, anything past the line store acts as its size
    function automatic int unsigned span_cols();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned span_rows();
        return (cfg_height == 0) ? 1 : 32'(cfg_height);
    endfunction

    // Advance the predictor by one accepted item and report the result it owes
    task automatic laplacian_step(input t_opcode op, input logic [7:0] pix,
                                  output bit due, output t_result res);
        int unsigned w, h, c, r;
        int          lap;
        logic [7:0]  mid;
        w   = span_cols();
        h   = span_rows();
        due = 1'b0;
        res = '0;
        if (op == OP_DRAIN) begin
            // drain releases one bottom-row zero, and only once a frame is complete
            if (draining) begin
                due = 1'b1;
                res.edge_pixel = EDGE_OFF;
                res.frame_end  = (drain_at + 1 >= w);
                if (res.frame_end) begin
                    draining = 1'b0;
                    drain_at = '0;
                end else begin
                    drain_at = drain_at + 1'b1;
                end
            end
        end else if (!draining) begin
            c = 32'(col_at);
            r = 32'(row_at);
            if (c >= MAX_W) c = MAX_W - 1;
            mid = rows_newer[c];
            due = (r >= 1);
            res.edge_pixel = EDGE_OFF;
            res.frame_end  = 1'b0;
            // only interior pixels get a Laplacian; borders stay zero
            if (due && r >= 2 && c >= 1 && c + 2 <= w && c + 1 < MAX_W) begin
                lap = int'(rows_older[c]) + int'(pix) + int'(left_pix)
                    + int'(rows_newer[c + 1]) - 4 * int'(mid);
                if (lap < 0) lap = -lap;
                if (lap > int'(cfg_thr)) res.edge_pixel = EDGE_ON;
            end
            left_pix      = mid;
            rows_older[c] = mid;
            rows_newer[c] = pix;
            if (c + 1 >= w) begin
                col_at = '0;
                if (r + 1 >= h) begin
                    row_at   = '0;
                    draining = 1'b1;
                    drain_at = '0;
                end else begin
                    row_at = 16'(r + 1);
                end
            end else begin
                col_at = 10'(c + 1);
            end
        end
    endtask

    // Receiver: stall at random or during a hold-off, and check each result item
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_edges.size() == 0) begin
                $display("%0t: result with none expected: edge_pixel %0d frame_end %0b",
                         $time, m_tdata, m_tlast);
                fails++;
            end else begin
                want = expected_edges.pop_front();
                if (m_tdata !== want.edge_pixel) begin
                    $display("%0t: edge_pixel expected %0d actual %0d",
                             $time, want.edge_pixel, m_tdata);
                    fails++;
                end
                if (m_tlast !== want.frame_end) begin
                    $display("%0t: frame_end expected %0b actual %0b",
                             $time, want.frame_end, m_tlast);
                    fails++;
                end
            end
        end
        m_tready <= !hold_rx && ($urandom_range(99) >= rx_pct);
    end

    // One APB transfer: setup phase, access phase, then a free phase
    task automatic apb_cycle(input logic [1:0] idx, input logic wr,
                             input logic [31:0] val, output logic [31:0] got);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        apb_cycle(idx, 1'b0, '0, got);
        if (got !== want) begin
            $display("%0t: register %0d read expected %0d actual %0d",
                     $time, idx, want, got);
            fails++;
        end
    endtask

    // Write a register, mirror it for the predictor, read it back
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] got;
        logic [31:0] want;
        apb_cycle(idx, 1'b1, val, got);
        want = '0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                cfg_width = val[IMG_W_W-1:0];
                want      = 32'(cfg_width);
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = val[IMG_H_W-1:0];
                want       = 32'(cfg_height);
            end
            default: begin
                cfg_thr = val[THR_W-1:0];
                want    = 32'(cfg_thr);
            end
        endcase
        check_reg(idx, want);
    endtask

    // Offer one item, idling first at random; return once it is accepted
    task automatic offer_item(input t_opcode op, input logic [7:0] pix);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= pix;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic feed(input t_opcode op, input logic [7:0] pix);
        bit      due;
        t_result res;
        offer_item(op, pix);
        laplacian_step(op, pix, due, res);
        if (due) expected_edges.push_back(res);
    endtask

    // Grey levels lean on black and white so strong edges are common
    function automatic logic [7:0] grey();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One whole frame plus its drain, with a little noise mixed in
    task automatic stream_frame(input int unsigned w, input int unsigned h, inout int tally);
        for (int unsigned n = 0; n < w * h; n++) begin
            if ($urandom_range(99) < 3) feed(OP_DRAIN, grey());   // dropped mid-frame
            feed(OP_PIXEL, grey());
            tally++;
        end
        if ($urandom_range(99) < 30) feed(OP_PIXEL, grey());      // dropped while draining
        for (int unsigned n = 0; n < w; n++) begin
            feed(OP_DRAIN, grey());
            tally++;
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_edges.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Small random frames, cycling through the size and threshold corners
    task automatic random_frames(input int budget);
        int          tally;
        logic [10:0] w_raw;
        logic [15:0] h_raw;
        logic [9:0]  thr;
        tally = 0;
        while (tally < budget) begin
            case (frame_no % 8)
                2:       w_raw = 11'd0;
                5:       w_raw = 11'd1;
                6:       w_raw = 11'd2;
                default: w_raw = 11'($urandom_range(3, 10));
            endcase
            case (frame_no % 8)
                0:       h_raw = 16'd0;
                1:       h_raw = 16'd1;
                default: h_raw = 16'($urandom_range(2, 6));
            endcase
            case (frame_no % 6)
                0:       thr = 10'd0;
                1:       thr = 10'd1;
                2:       thr = 10'd1020;
                3:       thr = 10'd1023;
                default: thr = 10'($urandom_range(1023));
            endcase
            settle();
            set_reg(REG_IMAGE_WIDTH, 32'(w_raw));
            set_reg(REG_IMAGE_HEIGHT, 32'(h_raw));
            set_reg(REG_EDGE_THRESHOLD, 32'(thr));
            stream_frame(span_cols(), span_rows(), tally);
            frame_no++;
        end
    endtask

    initial begin
        bit          due;
        t_result     res;
        t_step       row;
        int          tally;
        int          guard;

        tally = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers come out of reset at their documented defaults
        check_reg(REG_IMAGE_WIDTH, 32'(IMG_W_RST));
        check_reg(REG_IMAGE_HEIGHT, 32'(IMG_H_RST));
        check_reg(REG_EDGE_THRESHOLD, 32'(THR_RST));

        // Directed part: two 3x3 frames with hand-checked border and drain results
        set_reg(REG_IMAGE_WIDTH, 32'd3);
        set_reg(REG_IMAGE_HEIGHT, 32'd3);
        set_reg(REG_EDGE_THRESHOLD, 32'd30);
        tx_pct = 38;
        rx_pct = 38;
        foreach (bench_rows[k]) begin
            row = bench_rows[k];
            offer_item(row.op, row.pix);
            laplacian_step(row.op, row.pix, due, res);
            if (row.typed) begin
                if (row.due) expected_edges.push_back('{frame_end: row.last,
                                                        edge_pixel: row.edge_pixel});
            end else if (due) begin
                expected_edges.push_back(res);
            end
        end

        // Back-pressure: hold the receiver off while a frame streams in unthrottled
        settle();
        tx_pct = 0;
        rx_pct = 0;
        set_reg(REG_IMAGE_WIDTH, 32'd8);
        set_reg(REG_IMAGE_HEIGHT, 32'd5);
        set_reg(REG_EDGE_THRESHOLD, 32'd200);
        fork
            begin
                hold_rx <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        stream_frame(8, 5, tally);

        // Random part under each idling pattern
        tx_pct = 0;   rx_pct = 0;   random_frames(50);
        tx_pct = 69;  rx_pct = 0;   random_frames(50);
        tx_pct = 0;   rx_pct = 69;  random_frames(50);
        tx_pct = 38;  rx_pct = 38;  random_frames(50);

        // Widest row: register past the line store acts as its full size, so a
        // one-row frame starts draining after exactly MAX_W pixels
        settle();
        tx_pct = 0;
        rx_pct = 0;
        set_reg(REG_IMAGE_WIDTH, 32'd2047);
        set_reg(REG_IMAGE_HEIGHT, 32'd1);
        set_reg(REG_EDGE_THRESHOLD, 32'd0);
        repeat (MAX_W) feed(OP_PIXEL, grey());
        feed(OP_DRAIN, grey());
        // narrow the frame mid-drain so the next drain closes it
        settle();
        set_reg(REG_IMAGE_WIDTH, 32'd2);
        feed(OP_DRAIN, grey());
        feed(OP_DRAIN, grey());   // frame already closed: dropped

        // Tallest height, then cut the frame short mid-way and change threshold there
        settle();
        tx_pct = 38;
        rx_pct = 38;
        set_reg(REG_IMAGE_WIDTH, 32'd4);
        set_reg(REG_IMAGE_HEIGHT, 32'd65535);
        set_reg(REG_EDGE_THRESHOLD, 32'd100);
        repeat (5 * 4) feed(OP_PIXEL, grey());
        settle();
        set_reg(REG_IMAGE_HEIGHT, 32'd1);
        set_reg(REG_EDGE_THRESHOLD, 32'd5);
        repeat (4) feed(OP_PIXEL, grey());
        repeat (4) feed(OP_DRAIN, grey());

        // Let every owed result out, then wait on for stray ones
        s_tvalid <= 1'b0;
        rx_pct = 0;
        guard  = 0;
        while (expected_edges.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_edges.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_edges.size());
            fails++;
        end

        if (fails == 0) begin
            $display("** laplacian_edge_threshold: PASSED **");
        end else begin
            $display("** laplacian_edge_threshold: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5000000;
        $display("** laplacian_edge_threshold: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
src/lapedge_pkg.sv
src/lapedge_line_mem.sv
src/lapedge_skid.sv
src/laplacian_edge_threshold.sv
test/laplacian_edge_threshold_tb.sv
